[rtl/core/fst_pkg.sv]
// Shared types, constants and byte helpers for the stored-deflate stream framer.
// No dependencies; every module of the block imports this package.
`default_nettype none

package fst_pkg;

    // Wrapper selection as held in the mode register
    localparam logic WRAP_ZLIB = 1'b0;
    localparam logic WRAP_GZIP = 1'b1;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_WRAPPER_MODE   = 1'b0,
        CFG_PAYLOAD_LENGTH = 1'b1
    } cfg_idx_t;

    // Stored block limits and checksum constants
    localparam logic [31:0] STORED_BLOCK_MAX = 32'd65535;
    localparam logic [31:0] CRC_POLY         = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT         = 32'hFFFFFFFF;
    localparam logic [16:0] ADLER_MOD        = 17'd65521;

    // Frame header bytes
    localparam logic [7:0] ZLIB_CMF  = 8'h78;
    localparam logic [7:0] ZLIB_FLG  = 8'h01;
    localparam logic [7:0] GZIP_ID1  = 8'h1f;
    localparam logic [7:0] GZIP_ID2  = 8'h8b;
    localparam logic [7:0] GZIP_CM   = 8'h08;
    localparam logic [7:0] GZIP_OS   = 8'hff;

    // Index of the last byte in each emitted section
    localparam logic [3:0] HDR_LAST_ZLIB = 4'd1;
    localparam logic [3:0] HDR_LAST_GZIP = 4'd9;
    localparam logic [3:0] BLK_LAST      = 4'd4;
    localparam logic [3:0] DAT_LAST      = 4'd0;
    localparam logic [3:0] TRL_LAST_ZLIB = 4'd3;
    localparam logic [3:0] TRL_LAST_GZIP = 4'd7;

    // Command queue depth
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Section currently emitted by the back end
    typedef enum logic [1:0] {
        PH_HDR = 2'd0,
        PH_BLK = 2'd1,
        PH_DAT = 2'd2,
        PH_TRL = 2'd3
    } phase_t;

    // Latched configuration seen by the front end
    typedef struct packed {
        logic        mode;
        logic [31:0] length;
    } cfg_t;

    // Sections still to emit for the current command
    typedef struct packed {
        logic hdr;
        logic blk;
        logic dat;
        logic trl;
    } pend_t;

    // One classified item, front to back
    typedef struct packed {
        logic        hdr;
        logic        blk;
        logic        dat;
        logic        trl;
        logic        drop;
        logic        chk_rst;
        logic        mode;
        logic        blk_final;
        logic [15:0] blk_len;
        logic [7:0]  data;
        logic [31:0] isize;
    } cmd_t;

    // Byte idx of the frame header
    function automatic logic [7:0] hdr_byte(input logic mode, input logic [3:0] idx);
        logic [7:0] b;
        b = 8'h00;
        if (mode == WRAP_GZIP) begin
            case (idx)
                4'd0:    b = GZIP_ID1;
                4'd1:    b = GZIP_ID2;
                4'd2:    b = GZIP_CM;
                4'd9:    b = GZIP_OS;
                default: b = 8'h00;
            endcase
        end
        else begin
            b = (idx == 4'd0) ? ZLIB_CMF : ZLIB_FLG;
        end
        return b;
    endfunction

    // Reflected CRC-32 over one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/core/fst_if.sv]
// Handshake channel interfaces of the framer: payload in, framed stream out, config writes.
// No dependencies.
`default_nettype none

interface fst_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       empty_payload;

    modport source (output valid, data_byte, empty_payload, input ready);
    modport sink   (input valid, data_byte, empty_payload, output ready);
endinterface

interface fst_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       end_of_stream;
    logic       overrun;

    modport source (output valid, out_byte, last_of_run, end_of_stream, overrun, input ready);
    modport sink   (input valid, out_byte, last_of_run, end_of_stream, overrun, output ready);
endinterface

interface fst_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [31:0] wdata;

    modport source (output valid, index, wdata, input ready);
    modport sink   (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

[rtl/core/stored_deflate_stream_framer_top.sv]
// Top level of the stored-deflate stream framer: config registers, front end,
// command queue and back end. Depends on fst_pkg, fst_if, fst_front, fst_queue, fst_back.
//
//  Channel   Dir  Payload                                         Beat taken when
//  payload   in   data_byte[7:0], empty_payload                   valid && ready
//  stream    out  out_byte[7:0], last_of_run, end_of_stream,      valid && ready
//                 overrun
//  cfg       in   index (0 wrapper_mode, 1 payload_length),       valid && ready
//                 wdata[31:0]
//
// The back end emits one stream byte per cycle while the stream is ready; a plain payload
// byte yields 1 byte, a byte that opens a frame 1 + 2 (zlib) or 10 (gzip) + 5, one that
// opens a stored block 6, the final byte 5 (zlib) or 9 (gzip), an empty frame 11 or 23.
// A four-entry command queue lets payload beats keep arriving while headers and trailers
// drain; a beat passes the queue slot, the command register and the output register.
// Reset is asynchronous, active low; cfg is always ready and takes effect at the next frame.
`default_nettype none

module stored_deflate_stream_framer_top import fst_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    fst_in_if.sink     payload,
    fst_out_if.source  stream,
    fst_cfg_if.sink    cfg
);

    logic        mode_reg;
    logic [31:0] len_reg;
    cfg_t        cfg_val;
    cfg_idx_t    widx;

    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_nonempty;
    cmd_t        q_cmd;
    cmd_t        q_head;

    // Configuration registers
    assign cfg.ready = 1'b1;
    assign widx      = cfg_idx_t'(cfg.index);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= WRAP_ZLIB;
            len_reg  <= 32'd0;
        end
        else if (cfg.valid && cfg.ready) begin
            case (widx)
                CFG_WRAPPER_MODE:   mode_reg <= cfg.wdata[0];
                CFG_PAYLOAD_LENGTH: len_reg  <= cfg.wdata;
                default:            mode_reg <= mode_reg;
            endcase
        end
    end

    assign cfg_val.mode   = mode_reg;
    assign cfg_val.length = len_reg;

    fst_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_val (cfg_val),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (q_cmd),
        .payload (payload)
    );

    fst_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .full     (q_full),
        .nonempty (q_nonempty),
        .head     (q_head)
    );

    fst_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_nonempty (q_nonempty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .stream     (stream)
    );

    // The frame closes on the last byte of the beat that ends it
    a_eos_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        stream.valid && stream.end_of_stream |-> stream.last_of_run)
        else $error("end_of_stream without last_of_run");

    // A dropped beat is a single zero byte
    a_overrun_alone: assert property (@(posedge clk) disable iff (!rst_n)
        stream.valid && stream.overrun |->
            stream.last_of_run && !stream.end_of_stream && stream.out_byte == 8'h00)
        else $error("overrun beat malformed");

    // Payload is held off only while the command queue is full
    a_ready_from_queue: assert property (@(posedge clk) disable iff (!rst_n)
        !payload.ready |-> q_full && $past(q_push || !payload.ready))
        else $error("payload stalled with room in queue");

endmodule

`default_nettype wire

[rtl/core/fst_front.sv]
// Front end: accepts payload beats, tracks frame and block counters, builds commands.
// Depends on fst_pkg and fst_in_if.
`default_nettype none

module fst_front import fst_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg_val,
    input  logic  q_full,
    output logic  q_push,
    output cmd_t  q_cmd,
    fst_in_if.sink payload
);

    logic        open_reg,  open_next;
    logic        mode_reg,  mode_next;
    logic [31:0] flen_reg,  flen_next;
    logic [31:0] total_reg, total_next;
    logic [15:0] inblk_reg, inblk_next;

    logic        acc;
    logic [31:0] total_cur;
    logic [31:0] total_dec;
    logic [15:0] inblk_cur;
    logic [15:0] blk_len;
    logic [15:0] inblk_dec;
    logic        need_blk;
    logic        big;

    assign payload.ready = !q_full;
    assign acc           = payload.valid && payload.ready;
    assign q_push        = acc;

    // Counters as seen by this beat
    always_comb
    begin
        total_cur = open_reg ? total_reg : cfg_val.length;
        inblk_cur = open_reg ? inblk_reg : 16'd0;
        need_blk  = (inblk_cur == 16'd0);
        big       = (total_cur > STORED_BLOCK_MAX);
        blk_len   = big ? STORED_BLOCK_MAX[15:0] : total_cur[15:0];
        total_dec = total_cur - 32'd1;
        inblk_dec = (need_blk ? blk_len : inblk_cur) - 16'd1;
    end

    // Classify the beat and derive the next counter state
    always_comb
    begin
        q_cmd      = '0;
        q_cmd.data = payload.data_byte;
        open_next  = open_reg;
        mode_next  = mode_reg;
        flen_next  = flen_reg;
        total_next = total_reg;
        inblk_next = inblk_reg;

        if (payload.empty_payload) begin
            // whole empty frame, abandons any open frame
            q_cmd.hdr       = 1'b1;
            q_cmd.blk       = 1'b1;
            q_cmd.blk_final = 1'b1;
            q_cmd.trl       = 1'b1;
            q_cmd.chk_rst   = 1'b1;
            q_cmd.mode      = cfg_val.mode;
            open_next       = 1'b0;
            mode_next       = cfg_val.mode;
            flen_next       = 32'd0;
            total_next      = 32'd0;
            inblk_next      = 16'd0;
        end
        else if (!open_reg && cfg_val.length == 32'd0) begin
            // nothing expected: drop with overrun flag
            q_cmd.dat  = 1'b1;
            q_cmd.drop = 1'b1;
        end
        else begin
            q_cmd.hdr       = !open_reg;
            q_cmd.chk_rst   = !open_reg;
            q_cmd.mode      = open_reg ? mode_reg : cfg_val.mode;
            q_cmd.isize     = open_reg ? flen_reg : cfg_val.length;
            q_cmd.blk       = need_blk;
            q_cmd.blk_len   = blk_len;
            q_cmd.blk_final = !big;
            q_cmd.dat       = 1'b1;
            q_cmd.trl       = (total_dec == 32'd0);
            open_next       = (total_dec != 32'd0);
            mode_next       = q_cmd.mode;
            flen_next       = q_cmd.isize;
            total_next      = total_dec;
            inblk_next      = (total_dec == 32'd0) ? 16'd0 : inblk_dec;
        end
    end

    // Frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            open_reg  <= 1'b0;
            mode_reg  <= WRAP_ZLIB;
            flen_reg  <= 32'd0;
            total_reg <= 32'd0;
            inblk_reg <= 16'd0;
        end
        else if (acc) begin
            open_reg  <= open_next;
            mode_reg  <= mode_next;
            flen_reg  <= flen_next;
            total_reg <= total_next;
            inblk_reg <= inblk_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/fst_queue.sv]
// Short command queue between the front end and the back end.
// Depends on fst_pkg.
`default_nettype none

module fst_queue import fst_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic nonempty,
    output cmd_t head
);

    cmd_t               slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_reg, wr_next;
    logic [Q_PTR_W-1:0] rd_reg, rd_next;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign nonempty = (cnt_reg != '0);
    assign head     = slot_reg[rd_reg];

    // Pointer and count update
    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push) begin
            wr_next = (wr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop) begin
            rd_next = (rd_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push) begin
            slot_reg[wr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

[rtl/core/fst_back.sv]
// Back end: walks header, block header, data and trailer sections of each command,
// keeps the running CRC-32 and Adler-32, and drives the output register.
// Depends on fst_pkg and fst_out_if.
`default_nettype none

module fst_back import fst_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic q_nonempty,
    input  cmd_t q_head,
    output logic q_pop,
    fst_out_if.source stream
);

    cmd_t        cur_reg;
    pend_t       pend_reg, pend_next;
    logic [3:0]  idx_reg,  idx_next;
    logic [31:0] crc_reg,  crc_next;
    logic [15:0] alo_reg,  alo_next;
    logic [15:0] ahi_reg,  ahi_next;

    logic        ovld_reg;
    logic [7:0]  obyte_reg;
    logic        olast_reg;
    logic        oeos_reg;
    logic        oovr_reg;

    phase_t      phase;
    pend_t       pend_left;
    logic        busy;
    logic [3:0]  plast;
    logic        phase_end;
    logic        cmd_last;
    logic        adv;
    logic        upd;
    logic [7:0]  byte_val;
    logic [31:0] crc_fin;
    logic [16:0] lo_sum;
    logic [16:0] lo_mod;
    logic [16:0] hi_sum;
    logic [16:0] hi_mod;

    // Current section from the pending flags
    always_comb
    begin
        busy      = pend_reg.hdr | pend_reg.blk | pend_reg.dat | pend_reg.trl;
        pend_left = pend_reg;
        if (pend_reg.hdr) begin
            phase         = PH_HDR;
            pend_left.hdr = 1'b0;
        end
        else if (pend_reg.blk) begin
            phase         = PH_BLK;
            pend_left.blk = 1'b0;
        end
        else if (pend_reg.dat) begin
            phase         = PH_DAT;
            pend_left.dat = 1'b0;
        end
        else begin
            phase         = PH_TRL;
            pend_left.trl = 1'b0;
        end

        case (phase)
            PH_HDR:  plast = (cur_reg.mode == WRAP_GZIP) ? HDR_LAST_GZIP : HDR_LAST_ZLIB;
            PH_BLK:  plast = BLK_LAST;
            PH_DAT:  plast = DAT_LAST;
            PH_TRL:  plast = (cur_reg.mode == WRAP_GZIP) ? TRL_LAST_GZIP : TRL_LAST_ZLIB;
            default: plast = DAT_LAST;
        endcase
        phase_end = (idx_reg == plast);
        cmd_last  = phase_end && (pend_left == '0);
    end

    // Handshake with the queue and the output register
    assign adv   = busy && (!ovld_reg || stream.ready);
    assign q_pop = q_nonempty && (!busy || (adv && cmd_last));
    assign upd   = adv && (phase == PH_DAT) && !cur_reg.drop;

    // Byte selection
    always_comb
    begin
        crc_fin  = ~crc_reg;
        byte_val = 8'h00;
        case (phase)
            PH_HDR:
            begin
                byte_val = hdr_byte(cur_reg.mode, idx_reg);
            end
            PH_BLK:
            begin
                case (idx_reg)
                    4'd0:    byte_val = {7'd0, cur_reg.blk_final};
                    4'd1:    byte_val = cur_reg.blk_len[7:0];
                    4'd2:    byte_val = cur_reg.blk_len[15:8];
                    4'd3:    byte_val = ~cur_reg.blk_len[7:0];
                    4'd4:    byte_val = ~cur_reg.blk_len[15:8];
                    default: byte_val = 8'h00;
                endcase
            end
            PH_DAT:
            begin
                byte_val = cur_reg.drop ? 8'h00 : cur_reg.data;
            end
            PH_TRL:
            begin
                if (cur_reg.mode == WRAP_GZIP) begin
                    case (idx_reg)
                        4'd0:    byte_val = crc_fin[7:0];
                        4'd1:    byte_val = crc_fin[15:8];
                        4'd2:    byte_val = crc_fin[23:16];
                        4'd3:    byte_val = crc_fin[31:24];
                        4'd4:    byte_val = cur_reg.isize[7:0];
                        4'd5:    byte_val = cur_reg.isize[15:8];
                        4'd6:    byte_val = cur_reg.isize[23:16];
                        4'd7:    byte_val = cur_reg.isize[31:24];
                        default: byte_val = 8'h00;
                    endcase
                end
                else begin
                    case (idx_reg)
                        4'd0:    byte_val = ahi_reg[15:8];
                        4'd1:    byte_val = ahi_reg[7:0];
                        4'd2:    byte_val = alo_reg[15:8];
                        4'd3:    byte_val = alo_reg[7:0];
                        default: byte_val = 8'h00;
                    endcase
                end
            end
            default: byte_val = 8'h00;
        endcase
    end

    // Section walk and command load
    always_comb
    begin
        pend_next = pend_reg;
        idx_next  = idx_reg;
        if (q_pop) begin
            pend_next.hdr = q_head.hdr;
            pend_next.blk = q_head.blk;
            pend_next.dat = q_head.dat;
            pend_next.trl = q_head.trl;
            idx_next      = 4'd0;
        end
        else if (adv) begin
            if (phase_end) begin
                pend_next = pend_left;
                idx_next  = 4'd0;
            end
            else begin
                idx_next = idx_reg + 4'd1;
            end
        end
    end

    // Running checksums; a new frame clears them
    always_comb
    begin
        lo_sum   = {1'b0, alo_reg} + {9'd0, cur_reg.data};
        lo_mod   = (lo_sum >= ADLER_MOD) ? lo_sum - ADLER_MOD : lo_sum;
        hi_sum   = {1'b0, ahi_reg} + lo_mod;
        hi_mod   = (hi_sum >= ADLER_MOD) ? hi_sum - ADLER_MOD : hi_sum;
        crc_next = crc_reg;
        alo_next = alo_reg;
        ahi_next = ahi_reg;
        if (q_pop && q_head.chk_rst) begin
            crc_next = CRC_INIT;
            alo_next = 16'd1;
            ahi_next = 16'd0;
        end
        else if (upd) begin
            crc_next = crc_byte(crc_reg, cur_reg.data);
            alo_next = lo_mod[15:0];
            ahi_next = hi_mod[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pend_reg <= '0;
            idx_reg  <= 4'd0;
            crc_reg  <= CRC_INIT;
            alo_reg  <= 16'd1;
            ahi_reg  <= 16'd0;
            ovld_reg <= 1'b0;
        end
        else begin
            pend_reg <= pend_next;
            idx_reg  <= idx_next;
            crc_reg  <= crc_next;
            alo_reg  <= alo_next;
            ahi_reg  <= ahi_next;
            if (adv) begin
                ovld_reg <= 1'b1;
            end
            else if (stream.ready) begin
                ovld_reg <= 1'b0;
            end
        end
    end

    // Command and output payload
    always_ff @(posedge clk)
    begin
        if (q_pop) begin
            cur_reg <= q_head;
        end
        if (adv) begin
            obyte_reg <= byte_val;
            olast_reg <= cmd_last;
            oeos_reg  <= (phase == PH_TRL) && phase_end;
            oovr_reg  <= (phase == PH_DAT) && cur_reg.drop;
        end
    end

    assign stream.valid         = ovld_reg;
    assign stream.out_byte      = obyte_reg;
    assign stream.last_of_run   = olast_reg;
    assign stream.end_of_stream = oeos_reg;
    assign stream.overrun       = oovr_reg;

endmodule

`default_nettype wire
